// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator.
package bba_pkg;

   // Result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd2;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Nodes examined per scan cycle, and the width of a position inside one group
   localparam int SCAN_GROUP = 8;
   localparam int SCAN_SEL_W = 3;

   // Controller to datapath commands
   typedef struct packed {
      logic                capture;
      logic                scan_load;
      logic                scan_step;
      logic                sel_load;
      logic                spread;
      logic                apply;
      logic                walk;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } bba_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_free;
      logic alloc_bad;
      logic free_bad;
      logic scan_hit;
      logic scan_last;
   } bba_stat_type;

endpackage

// ===== hw/rtl/buddy_block_allocator.sv =====
// Buddy block allocator: one occupied bit per node of a complete binary tree.
//
// Request word (req_*): kind 0 allocates req_request_size bytes, kind 1 frees
// the block req_free_start..req_free_end. One response word (rsp_*) follows
// each request: status, and for a successful allocation the block range.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// One request is in work at a time; req_stall is low only while idle.
// A rejected request (bad size, occupied root, bad free range) goes from decode
// straight to its response. A free marks its block, spreads the mark down and
// walks up the parents. An allocate lets the subtree flags settle, scans the
// target level in 8-node groups (1..16 groups for 8-byte blocks at the default
// sizes), spreads the mark down and applies it; one that finds no free block
// ends with the scan. The level scan examines eight nodes a cycle; the spread
// and walk move through the tree one level per cycle. A new request is taken
// the cycle after the response is loaded, even while that response still waits.
// Reset marks every node free and drops any pending response.
// A stalled response holds; a finished request then waits to load its result.
module buddy_block_allocator #(
   parameter int MEMORY_BYTES = 1024,
   parameter int TREE_LEVELS  = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [$clog2(MEMORY_BYTES):0]    req_request_size,
   input  logic [$clog2(MEMORY_BYTES)-1:0]  req_free_start,
   input  logic [$clog2(MEMORY_BYTES)-1:0]  req_free_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   output logic [$clog2(MEMORY_BYTES)-1:0]  rsp_block_start,
   output logic [$clog2(MEMORY_BYTES)-1:0]  rsp_block_end
);

   bba_pkg::bba_cmd_type  cmd;
   bba_pkg::bba_stat_type stat;

   bba_ctrl #(
      .TREE_LEVELS (TREE_LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_datapath #(
      .MEMORY_BYTES (MEMORY_BYTES),
      .TREE_LEVELS  (TREE_LEVELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_request_size (req_request_size),
      .req_free_start   (req_free_start),
      .req_free_end     (req_free_end),
      .rsp_status       (rsp_status),
      .rsp_block_start  (rsp_block_start),
      .rsp_block_end    (rsp_block_end)
   );

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// Sequencing state machine of the buddy block allocator.
module bba_ctrl #(
   parameter int TREE_LEVELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bba_pkg::bba_stat_type stat,
   output bba_pkg::bba_cmd_type  cmd
);

   localparam int CNT_W = $clog2(TREE_LEVELS);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_SETTLE = 9'b000000100,
      ST_LOAD   = 9'b000001000,
      ST_SCAN   = 9'b000010000,
      ST_SPREAD = 9'b000100000,
      ST_APPLY  = 9'b001000000,
      ST_WALK   = 9'b010000000,
      ST_FINISH = 9'b100000000
   } bba_state_type;

   bba_state_type                  state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [bba_pkg::STATUS_W-1:0]   code_ff, code_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.rsp_status = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cnt_in = '0;
            if (stat.is_free) begin
               if (stat.free_bad) begin
                  code_in  = bba_pkg::STATUS_BAD_RANGE;
                  state_in = ST_FINISH;
               end else begin
                  cmd.sel_load = 1'b1;
                  code_in      = bba_pkg::STATUS_OK;
                  state_in     = ST_SPREAD;
               end
            end else if (stat.alloc_bad) begin
               code_in  = bba_pkg::STATUS_NO_FIT;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // let the subtree occupancy flags ripple up to the root
            if (cnt_ff == CNT_W'(TREE_LEVELS - 1)) begin
               cnt_in   = '0;
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            cmd.scan_load = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_hit) begin
               cmd.sel_load = 1'b1;
               code_in      = bba_pkg::STATUS_OK;
               cnt_in       = '0;
               state_in     = ST_SPREAD;
            end else if (stat.scan_last) begin
               code_in  = bba_pkg::STATUS_NO_FIT;
               state_in = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SPREAD: begin
            cmd.spread = 1'b1;
            if (cnt_ff == CNT_W'(TREE_LEVELS - 2)) begin
               cnt_in   = '0;
               state_in = ST_APPLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            cnt_in    = '0;
            state_in  = stat.is_free ? ST_WALK : ST_FINISH;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (cnt_ff == CNT_W'(TREE_LEVELS - 2)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         code_ff      <= bba_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/bba_datapath.sv =====
// Occupancy tree, level scan, subtree marking and result register of the allocator.
module bba_datapath #(
   parameter int MEMORY_BYTES = 1024,
   parameter int TREE_LEVELS  = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bba_pkg::bba_cmd_type             cmd,
   output bba_pkg::bba_stat_type            stat,
   input  logic                             req_kind,
   input  logic [$clog2(MEMORY_BYTES):0]    req_request_size,
   input  logic [$clog2(MEMORY_BYTES)-1:0]  req_free_start,
   input  logic [$clog2(MEMORY_BYTES)-1:0]  req_free_end,
   output logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   output logic [$clog2(MEMORY_BYTES)-1:0]  rsp_block_start,
   output logic [$clog2(MEMORY_BYTES)-1:0]  rsp_block_end
);

   localparam int ADDR_W    = $clog2(MEMORY_BYTES);
   localparam int SIZE_W    = ADDR_W + 1;
   localparam int NODES     = (1 << TREE_LEVELS) - 1;
   localparam int LEAF_BASE = 1 << (TREE_LEVELS - 1);
   localparam int NODE_W    = TREE_LEVELS;
   localparam int POS_W     = TREE_LEVELS - 1;
   localparam int LVL_W     = $clog2(TREE_LEVELS + 1);
   localparam int SCAN_W    =
      ((LEAF_BASE + bba_pkg::SCAN_GROUP - 1) / bba_pkg::SCAN_GROUP) * bba_pkg::SCAN_GROUP;
   localparam int GROUPS    = SCAN_W / bba_pkg::SCAN_GROUP;
   localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // captured request
   logic                  kind_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [ADDR_W-1:0]     fstart_ff;
   logic [ADDR_W-1:0]     fend_ff;

   // tree state: node bits, subtree flags, marking and walk tokens
   logic [NODES:1]        occ_ff, occ_in;
   logic [NODES:1]        busy_ff, busy_in;
   logic [NODES:1]        sel_ff, sel_in;
   logic [NODES:1]        up_ff, up_in;
   logic [LEAF_BASE-1:1]  move;

   logic [SCAN_W-1:0]     scan_ff, scan_in, lvl_busy;
   logic [GRP_W-1:0]      group_ff, group_in, lvl_last;

   logic [ADDR_W-1:0]     blk_start_ff, blk_end_ff;
   logic [bba_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_start_ff, rsp_end_ff;

   logic [LVL_W-1:0]      tgt;
   logic                  fr_hit;
   logic [NODE_W-1:0]     fr_node;
   logic [bba_pkg::SCAN_SEL_W-1:0] pe;
   logic                  hit;
   logic [POS_W-1:0]      pos;
   logic [NODE_W-1:0]     al_node, node_pick;
   logic [ADDR_W-1:0]     al_start, al_end;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         size_ff   <= req_request_size;
         fstart_ff <= req_free_start;
         fend_ff   <= req_free_end;
      end
   end

   // deepest level whose block still holds the request
   always_comb begin
      tgt = '0;
      for (int l = 1; l <= TREE_LEVELS; l++) begin
         if (SIZE_W'(MEMORY_BYTES >> (l - 1)) >= size_ff) begin
            tgt = LVL_W'(l);
         end
      end
   end

   // a freed range must be exactly one aligned block
   always_comb begin
      fr_hit  = 1'b0;
      fr_node = '0;
      for (int l = 1; l <= TREE_LEVELS; l++) begin
         if (l - 1 <= ADDR_W) begin
            if ((fstart_ff & ADDR_W'((1 << (ADDR_W - (l - 1))) - 1)) == '0 &&
                fend_ff == (fstart_ff | ADDR_W'((1 << (ADDR_W - (l - 1))) - 1))) begin
               fr_hit  = 1'b1;
               fr_node = NODE_W'(1 << (l - 1)) | NODE_W'(fstart_ff >> (ADDR_W - (l - 1)));
            end
         end
      end
   end

   // subtree flags ripple up one level per cycle
   always_comb begin
      busy_in = occ_ff;
      for (int n = 1; n < LEAF_BASE; n++) begin
         busy_in[n] = occ_ff[n] | busy_ff[2*n] | busy_ff[2*n+1];
      end
   end

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   // target level's subtree flags, padded busy past the level's last node
   always_comb begin
      lvl_busy = '1;
      lvl_last = '0;
      for (int l = 1; l <= TREE_LEVELS; l++) begin
         if (tgt == LVL_W'(l)) begin
            lvl_last = GRP_W'(((1 << (l - 1)) - 1) / bba_pkg::SCAN_GROUP);
            for (int k = 0; k < (1 << (l - 1)); k++) begin
               lvl_busy[k] = busy_ff[(1 << (l - 1)) + k];
            end
         end
      end
   end

   always_comb begin
      scan_in  = scan_ff;
      group_in = group_ff;
      if (cmd.scan_load) begin
         scan_in  = lvl_busy;
         group_in = '0;
      end else if (cmd.scan_step) begin
         scan_in = '1;
         for (int k = 0; k < SCAN_W - bba_pkg::SCAN_GROUP; k++) begin
            scan_in[k] = scan_ff[k + bba_pkg::SCAN_GROUP];
         end
         group_in = group_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      group_ff <= group_in;
   end

   // leftmost free node of the current group
   always_comb begin
      pe = '0;
      for (int k = bba_pkg::SCAN_GROUP - 1; k >= 0; k--) begin
         if (!scan_ff[k]) begin
            pe = bba_pkg::SCAN_SEL_W'(k);
         end
      end
   end

   assign hit = ~&scan_ff[bba_pkg::SCAN_GROUP-1:0];
   assign pos = POS_W'({group_ff, pe});

   always_comb begin
      al_node  = '0;
      al_start = '0;
      al_end   = '0;
      for (int l = 1; l <= TREE_LEVELS; l++) begin
         if (tgt == LVL_W'(l) && l - 1 <= ADDR_W) begin
            al_node  = NODE_W'(1 << (l - 1)) | NODE_W'(pos);
            al_start = ADDR_W'(pos) << (ADDR_W - (l - 1));
            al_end   = (ADDR_W'(pos) << (ADDR_W - (l - 1))) |
                       ADDR_W'((1 << (ADDR_W - (l - 1))) - 1);
         end
      end
   end

   assign node_pick = (kind_ff == bba_pkg::KIND_FREE) ? fr_node : al_node;

   always_ff @(posedge clock) begin
      if (cmd.sel_load) begin
         blk_start_ff <= al_start;
         blk_end_ff   <= al_end;
      end
   end

   // mark the chosen node, then spread the mark down one level per cycle
   always_comb begin
      sel_in = sel_ff;
      if (cmd.sel_load) begin
         for (int n = 1; n <= NODES; n++) begin
            sel_in[n] = (node_pick == NODE_W'(n));
         end
      end else if (cmd.spread) begin
         for (int n = 2; n <= NODES; n++) begin
            sel_in[n] = sel_ff[n] | sel_ff[n >> 1];
         end
      end
   end

   // a parent clears when the token sits on a child and both children are free
   always_comb begin
      for (int m = 1; m < LEAF_BASE; m++) begin
         move[m] = (up_ff[2*m] | up_ff[2*m+1]) & ~occ_ff[2*m] & ~occ_ff[2*m+1];
      end
   end

   always_comb begin
      up_in = up_ff;
      if (cmd.sel_load) begin
         up_in = sel_in;
      end else if (cmd.walk) begin
         up_in = '0;
         for (int m = 1; m < LEAF_BASE; m++) begin
            up_in[m] = move[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      up_ff  <= up_in;
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.apply) begin
         occ_in = (kind_ff == bba_pkg::KIND_FREE) ? (occ_ff & ~sel_ff) : (occ_ff | sel_ff);
      end else if (cmd.walk) begin
         for (int m = 1; m < LEAF_BASE; m++) begin
            if (move[m]) begin
               occ_in[m] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // result word: range only for a successful allocation
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == bba_pkg::STATUS_OK && kind_ff == bba_pkg::KIND_ALLOC) begin
            rsp_start_ff <= blk_start_ff;
            rsp_end_ff   <= blk_end_ff;
         end else begin
            rsp_start_ff <= '0;
            rsp_end_ff   <= '0;
         end
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_block_start = rsp_start_ff;
   assign rsp_block_end   = rsp_end_ff;

   assign stat.is_free   = (kind_ff == bba_pkg::KIND_FREE);
   assign stat.alloc_bad = (size_ff == '0) || (size_ff > SIZE_W'(MEMORY_BYTES)) || occ_ff[1];
   assign stat.free_bad  = ~fr_hit;
   assign stat.scan_hit  = hit;
   assign stat.scan_last = (group_ff == lvl_last);

endmodule
